FILE: rtl/core/bqf_pkg.sv
// Shared types and constants for the biquad low-pass filter.
package bqf_pkg;

	// Field widths
	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 32;
	localparam int FRAC_W   = COEF_W - 2;        // coefficient fraction bits (Q2.30)
	localparam int PROD_W   = SAMPLE_W + COEF_W; // full product width
	localparam int ACC_W    = PROD_W + 3;        // headroom for five terms
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd5;

	typedef logic signed [SAMPLE_W-1:0] bqf_sample_t;
	typedef logic signed [COEF_W-1:0]   bqf_coef_word_t;
	typedef logic signed [ACC_W-1:0]    bqf_acc_t;

	// Coefficient set handed to the multiply-accumulate datapath
	typedef struct packed {
		bqf_coef_word_t b0;
		bqf_coef_word_t b1;
		bqf_coef_word_t b2;
		bqf_coef_word_t a1;
		bqf_coef_word_t a2;
	} bqf_coef_t;

	// Rounding offset: half an LSB of the result
	localparam bqf_acc_t ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

	// Saturation bounds, in accumulator and in sample width
	localparam bqf_acc_t ACC_SAT_MAX = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
	localparam bqf_acc_t ACC_SAT_MIN = -(ACC_W'(1) <<< (SAMPLE_W - 1));
	localparam bqf_sample_t SMP_MAX  = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam bqf_sample_t SMP_MIN  = {1'b1, {(SAMPLE_W - 1){1'b0}}};

endpackage

FILE: rtl/core/bqf_if.sv
// Valid/ready stream interfaces for the filter input and output channels.
interface bqf_in_if import bqf_pkg::*; ();
	logic        valid;
	logic        ready;
	bqf_sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqf_out_if import bqf_pkg::*; ();
	logic        valid;
	logic        ready;
	bqf_sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: rtl/core/bqf_mac.sv
// Biquad multiply-accumulate datapath: five products, round, saturate.
module bqf_mac import bqf_pkg::*; (
	input  bqf_coef_t   coef,
	input  bqf_sample_t x0,
	input  bqf_sample_t x1,
	input  bqf_sample_t x2,
	input  bqf_sample_t y1,
	input  bqf_sample_t y2,
	output bqf_sample_t y0
);

	logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	bqf_acc_t acc;
	bqf_acc_t acc_sh;
	logic sat_hi, sat_lo;

	// Five independent products, full width
	assign p_b0 = $signed(coef.b0) * x0;
	assign p_b1 = $signed(coef.b1) * x1;
	assign p_b2 = $signed(coef.b2) * x2;
	assign p_a1 = $signed(coef.a1) * y1;
	assign p_a2 = $signed(coef.a2) * y2;

	// Exact sum with rounding offset
	assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
		- ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_HALF;

	// Drop coefficient fraction bits (floor after the half-LSB add)
	assign acc_sh = acc >>> FRAC_W;

	// Clamp to the sample range
	assign sat_hi = acc_sh > ACC_SAT_MAX;
	assign sat_lo = acc_sh < ACC_SAT_MIN;
	assign y0 = sat_hi ? SMP_MAX : (sat_lo ? SMP_MIN : acc_sh[SAMPLE_W-1:0]);

endmodule

FILE: rtl/core/biquad_lowpass_filter.sv
// A sample accepted into the input register is filtered and captured in the output register.
// Throughput: one sample per cycle while the output is not stalled; the feedback path
// (five products, sum, round, saturate, back into the output history) is combinational.
// Reset (arst_n low, asynchronous): filter disabled, coefficients and the
// input/output history cleared, both stages empty.
module biquad_lowpass_filter import bqf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bqf_in_if.sink                in_ch,
	bqf_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_W-1:0]     cfg_data
);

	logic        enable_q;
	bqf_coef_t   coef_q;
	bqf_sample_t x1_q, x2_q, y1_q, y2_q;
	bqf_sample_t x_s1;
	logic        valid_s1;
	bqf_sample_t out_q;
	logic        out_valid_q;
	bqf_sample_t y_new;
	logic        advance;
	logic        in_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			coef_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q  <= cfg_data[0];
				REG_B0:     coef_q.b0 <= cfg_data;
				REG_B1:     coef_q.b1 <= cfg_data;
				REG_B2:     coef_q.b2 <= cfg_data;
				REG_A1:     coef_q.a1 <= cfg_data;
				REG_A2:     coef_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves when the output register is free or draining
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_take      = in_ch.valid && in_ch.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_s1 <= in_ch.sample_in;
		end
	end

	// Filter datapath
	bqf_mac u_mac (
		.coef (coef_q),
		.x0   (x_s1),
		.x1   (x1_q),
		.x2   (x2_q),
		.y1   (y1_q),
		.y2   (y2_q),
		.y0   (y_new)
	);

	// History, updated only for filtered samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (advance && enable_q) begin
			x1_q <= x_s1;
			x2_q <= x1_q;
			y1_q <= y_new;
			y2_q <= y1_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= enable_q ? y_new : x_s1;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_q;

endmodule

FILE: tb/sv/biquad_lowpass_filter_tb.sv
// Self-checking testbench for the biquad low-pass filter: directed and random sample streams.
module biquad_lowpass_filter_tb;
	import bqf_pkg::*;

	// Register indexes the block does not decode; writes to them must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [COEF_W-1:0] COEF_ONE     = 32'h4000_0000;
	localparam logic [COEF_W-1:0] COEF_HALF    = 32'h2000_0000;
	localparam logic [COEF_W-1:0] COEF_NEG_ONE = 32'hC000_0000;
	localparam logic [COEF_W-1:0] COEF_MAX     = 32'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] COEF_MIN     = 32'h8000_0000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	bqf_in_if  in_ch ();
	bqf_out_if out_ch ();

	biquad_lowpass_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	int send_idle_pct;
	int recv_idle_pct;
	int failures;

	// Output samples still owed by the block, oldest first
	bqf_sample_t expected_out[$];
	bqf_sample_t expected_head;

	// Filter state and register copies kept by the testbench
	bit             flt_enable;
	bqf_coef_word_t flt_b0, flt_b1, flt_b2, flt_a1, flt_a2;
	bqf_sample_t    hist_x1, hist_x2, hist_y1, hist_y2;

	// Clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Output side stalls at random
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Next output of the filter; advances the history when enabled
	function automatic bqf_sample_t filter_next(input bqf_sample_t x);
		logic signed [63:0] acc;
		logic signed [63:0] rounded;
		bqf_sample_t        y;
		if (!flt_enable)
			return x;
		acc = 64'(flt_b0) * 64'(x) + 64'(flt_b1) * 64'(hist_x1)
			+ 64'(flt_b2) * 64'(hist_x2) - 64'(flt_a1) * 64'(hist_y1)
			- 64'(flt_a2) * 64'(hist_y2);
		rounded = (acc + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
		if (rounded > 64'(SMP_MAX))
			y = SMP_MAX;
		else if (rounded < 64'(SMP_MIN))
			y = SMP_MIN;
		else
			y = rounded[SAMPLE_W-1:0];
		hist_x2 = hist_x1;
		hist_x1 = x;
		hist_y2 = hist_y1;
		hist_y1 = y;
		return y;
	endfunction

	// Compare every output transaction with the oldest expected sample
	always @(posedge clk) begin
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_out.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected output sample %0d", out_ch.sample_out);
			end else begin
				expected_head = expected_out.pop_front();
				if (out_ch.sample_out !== expected_head) begin
					failures++;
					if (failures <= 10)
						$display("sample_out wrong: expected %0d, got %0d",
							expected_head, out_ch.sample_out);
				end
			end
		end
	end

	// Send one sample; called and returns at a falling edge, valid left high
	task automatic send_sample(input bqf_sample_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		expected_out.push_back(filter_next(s));
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected sample has come out
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	// One register write; write enable stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		case (idx)
			REG_ENABLE: flt_enable = data[0];
			REG_B0:     flt_b0 = data;
			REG_B1:     flt_b1 = data;
			REG_B2:     flt_b2 = data;
			REG_A1:     flt_a1 = data;
			REG_A2:     flt_a2 = data;
			default:    ;
		endcase
	endtask

	// Enable alone, upper data bits random
	task automatic set_enable(input bit en);
		wait_drained();
		write_reg(REG_ENABLE, ($urandom() & ~32'h1) | 32'(en));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Full coefficient set plus a stray write to an undecoded index
	task automatic load_config(input bit en, input logic [COEF_W-1:0] b0, b1, b2, a1, a2);
		wait_drained();
		write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		write_reg(REG_ENABLE, ($urandom() & ~32'h1) | 32'(en));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic bqf_sample_t rand_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return bqf_sample_t'($urandom());
			5, 6:          return bqf_sample_t'($urandom_range(0, 511)) - 24'sd256;
			7:             return SMP_MAX;
			8:             return SMP_MIN;
			default:       return $urandom_range(0, 1) ? 24'sd0 : -24'sd1;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef(input int style);
		case (style)
			0:       return $urandom();
			1: begin
				case ($urandom_range(0, 4))
					0:       return COEF_MAX;
					1:       return COEF_MIN;
					2:       return COEF_ONE;
					3:       return COEF_NEG_ONE;
					default: return '0;
				endcase
			end
			default: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
		endcase
	endfunction

	// Reset values: pass-through, then zero coefficients and history
	task automatic test_reset_state();
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		send_sample(24'sd0);
		send_sample(-24'sd1);
		send_sample(24'h555555);
		send_sample(24'hAAAAAA);
		set_enable(1'b1);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
	endtask

	task automatic test_unity_gain();
		load_config(1'b1, COEF_ONE, '0, '0, '0, '0);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(24'sd1);
	endtask

	// Halfway cases round toward plus infinity
	task automatic test_rounding_ties();
		load_config(1'b1, COEF_HALF, '0, '0, '0, '0);
		send_sample(24'sd1);
		send_sample(-24'sd1);
		send_sample(24'sd3);
		send_sample(-24'sd3);
	endtask

	// Extreme coefficients drive the sum far past both rails
	task automatic test_saturation();
		load_config(1'b1, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
	endtask

	// Integrator saturates into its history; bypass leaves the history alone
	task automatic test_feedback_bypass();
		load_config(1'b1, COEF_ONE, '0, '0, COEF_NEG_ONE, '0);
		send_sample(SMP_MAX);
		send_sample(SMP_MAX);
		set_enable(1'b0);
		send_sample(24'sd1234);
		send_sample(SMP_MIN);
		set_enable(1'b1);
		send_sample(SMP_MIN);
	endtask

	// Random coefficient sets, each followed by a burst of samples
	task automatic test_random(input int n_items);
		int                sent;
		int                burst;
		int                style;
		logic [COEF_W-1:0] b0;
		sent = 0;
		while (sent < n_items) begin
			style = $urandom_range(0, 3);
			if (style == 3) begin
				// stable-ish low-pass shape
				b0 = $urandom_range(0, 32'h0400_0000);
				load_config($urandom_range(0, 9) != 0, b0, b0 << 1, b0,
					-$urandom_range(32'h4000_0000, 32'h7FFF_0000),
					$urandom_range(32'h1000_0000, 32'h4000_0000));
			end else begin
				load_config($urandom_range(0, 4) != 0, rand_coef(style), rand_coef(style),
					rand_coef(style), rand_coef(style), rand_coef(style));
			end
			burst = $urandom_range(10, 30);
			repeat (burst) begin
				send_sample(rand_sample());
				if ($urandom_range(0, 39) == 0)
					wait_drained();
			end
			sent += burst;
		end
	endtask

	// Main sequence
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_ch.valid   = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready  = 1'b0;
		failures      = 0;
		send_idle_pct = 25;
		recv_idle_pct = 86;
		flt_enable    = 1'b0;
		flt_b0 = '0; flt_b1 = '0; flt_b2 = '0; flt_a1 = '0; flt_a2 = '0;
		hist_x1 = '0; hist_x2 = '0; hist_y1 = '0; hist_y2 = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_unity_gain();
		test_rounding_ties();
		test_saturation();
		test_feedback_bypass();
		test_random(110);

		send_idle_pct = 86;
		recv_idle_pct = 25;
		test_random(130);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(130);

		wait_drained();
		repeat (3) @(posedge clk);
		if (failures == 0 && expected_out.size() == 0)
			$display("biquad_lowpass_filter: match");
		else
			$display("biquad_lowpass_filter: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#6_000_000;
		$display("biquad_lowpass_filter: mismatch");
		$finish;
	end

endmodule

FILE: biquad_lowpass_filter.f
rtl/core/bqf_pkg.sv
rtl/core/bqf_if.sv
rtl/core/bqf_mac.sv
rtl/core/biquad_lowpass_filter.sv
tb/sv/biquad_lowpass_filter_tb.sv
